/* sv/pngcsp_pkg.sv */
// ----------------------------------------------------------------------------
// PNG chunk stream parser package
// Shared types, codes and constants of the PNG chunk stream parser.
// ----------------------------------------------------------------------------
package pngcsp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned EVENT_W    = 3;
    localparam int unsigned HDR_BYTES  = 5;
    localparam int unsigned SIG_LEN    = 8;

    // Output packing widths
    localparam int unsigned OUT_DATA_W = 4 * WORD_W + HDR_BYTES * BYTE_W + BYTE_W;
    localparam int unsigned OUT_USER_W = EVENT_W + 1;

    localparam logic [WORD_W-1:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [WORD_W-1:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [WORD_W-1:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [WORD_W-1:0] IHDR_LEN  = 32'd13;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5,
        PH_ERR  = 3'd6
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_CHUNK    = 3'd1,
        EV_IHDR     = 3'd2,
        EV_IEND     = 3'd3,
        EV_SIG_ERR  = 3'd4
    } event_t;

    typedef struct packed {
        event_t              event_res;
        logic [WORD_W-1:0]   chunk_length;
        logic [WORD_W-1:0]   chunk_type;
        logic [WORD_W-1:0]   image_width;
        logic [WORD_W-1:0]   image_height;
        logic [BYTE_W-1:0]   sample_depth;
        logic [BYTE_W-1:0]   color_mode;
        logic [BYTE_W-1:0]   compression_method;
        logic [BYTE_W-1:0]   filter_method;
        logic [BYTE_W-1:0]   interlace_method;
        logic                image_data_valid;
        logic [BYTE_W-1:0]   image_data_byte;
    } result_t;

    // Expected PNG signature byte at a given position.
    function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'd137;
            3'd1:    b = 8'd80;
            3'd2:    b = 8'd78;
            3'd3:    b = 8'd71;
            3'd4:    b = 8'd13;
            3'd5:    b = 8'd10;
            3'd6:    b = 8'd26;
            3'd7:    b = 8'd10;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

/* sv/png_chunk_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// PNG chunk stream parser
// Walks a PNG byte stream: signature check, chunk headers, IHDR capture and
// flagged IDAT payload bytes.
// ----------------------------------------------------------------------------
// Each byte of the file enters as one item and gives exactly one result item,
// which shows the parser state after that byte. The byte is parsed by the
// state logic in the cycle it is accepted and the result is registered, so a
// byte is taken in every cycle while the output side takes results. A
// signature error is sticky and reports on every later byte; after the IEND
// CRC every byte gives an empty event until reset. CRC bytes are skipped
// without being checked, and chunk order is not checked.
// ----------------------------------------------------------------------------
module png_chunk_stream_parser_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pngcsp_pkg::BYTE_W-1:0]     s_axis_tdata,   // stream_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // chunk_length, chunk_type, image_width, image_height, sample_depth,
    // color_mode, compression_method, filter_method, interlace_method,
    // image_data_byte
    output logic [pngcsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // event_res, image_data_valid
    output logic [pngcsp_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    logic                accept;
    logic                take;
    logic                busy;
    pngcsp_pkg::result_t res_comb;
    pngcsp_pkg::result_t res_q;

    assign take          = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pngcsp_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (s_axis_tdata),
        .res         (res_comb)
    );

    pngcsp_out_reg u_out_reg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .res_in  (res_comb),
        .take    (take),
        .busy    (busy),
        .valid   (m_axis_tvalid),
        .res_out (res_q)
    );

    assign m_axis_tdata = {res_q.image_data_byte,
                           res_q.interlace_method,
                           res_q.filter_method,
                           res_q.compression_method,
                           res_q.color_mode,
                           res_q.sample_depth,
                           res_q.image_height,
                           res_q.image_width,
                           res_q.chunk_type,
                           res_q.chunk_length};

    assign m_axis_tuser = {res_q.image_data_valid, res_q.event_res};

endmodule

/* sv/pngcsp_parse.sv */
// ----------------------------------------------------------------------------
// PNG chunk parser state
// Holds the parse state and computes, for each byte, the next state and the
// result item that shows the state after that byte.
// ----------------------------------------------------------------------------
module pngcsp_parse
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [pngcsp_pkg::BYTE_W-1:0] stream_byte,
    output pngcsp_pkg::result_t           res
);

    pngcsp_pkg::phase_t              phase_reg,  phase_next;
    logic [pngcsp_pkg::WORD_W-1:0]   pos_reg,    pos_next;
    logic [pngcsp_pkg::WORD_W-1:0]   len_reg,    len_next;
    logic [pngcsp_pkg::WORD_W-1:0]   type_reg,   type_next;
    logic [pngcsp_pkg::WORD_W-1:0]   width_reg,  width_next;
    logic [pngcsp_pkg::WORD_W-1:0]   height_reg, height_next;
    logic [pngcsp_pkg::BYTE_W-1:0]   hdr_reg  [pngcsp_pkg::HDR_BYTES];
    logic [pngcsp_pkg::BYTE_W-1:0]   hdr_next [pngcsp_pkg::HDR_BYTES];
    logic                            last_reg,   last_next;

    logic [pngcsp_pkg::WORD_W-1:0]   pos_inc;
    logic [pngcsp_pkg::WORD_W-1:0]   type_shift;
    logic [2:0]                      hdr_idx;
    pngcsp_pkg::event_t              ev;
    logic                            dv;

    assign pos_inc    = pos_reg + 32'd1;
    assign type_shift = {type_reg[pngcsp_pkg::WORD_W-9:0], stream_byte};
    // Header bytes sit at data positions 8 to 12.
    assign hdr_idx    = 3'(pos_reg[3:0] - 4'd8);

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        width_next  = width_reg;
        height_next = height_reg;
        hdr_next    = hdr_reg;
        last_next   = last_reg;
        ev          = pngcsp_pkg::EV_NONE;
        dv          = 1'b0;

        case (phase_reg)
            pngcsp_pkg::PH_SIG:
            begin
                if (stream_byte != pngcsp_pkg::sig_byte(pos_reg[2:0]))
                begin
                    phase_next = pngcsp_pkg::PH_ERR;
                    pos_next   = '0;
                    ev         = pngcsp_pkg::EV_SIG_ERR;
                end
                else if (pos_reg[2:0] == 3'd7)
                begin
                    phase_next = pngcsp_pkg::PH_LEN;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            pngcsp_pkg::PH_LEN:
            begin
                len_next = {len_reg[pngcsp_pkg::WORD_W-9:0], stream_byte};
                if (pos_reg[1:0] == 2'd3)
                begin
                    phase_next = pngcsp_pkg::PH_TYPE;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            pngcsp_pkg::PH_TYPE:
            begin
                type_next = type_shift;
                if (pos_reg[1:0] == 2'd3)
                begin
                    pos_next  = '0;
                    ev        = pngcsp_pkg::EV_CHUNK;
                    last_next = (type_shift == pngcsp_pkg::TYPE_IEND);
                    if (type_shift == pngcsp_pkg::TYPE_IHDR)
                    begin
                        width_next  = '0;
                        height_next = '0;
                        for (int i = 0; i < pngcsp_pkg::HDR_BYTES; i++)
                        begin
                            hdr_next[i] = '0;
                        end
                    end
                    phase_next = (len_reg != '0) ? pngcsp_pkg::PH_DATA
                                                 : pngcsp_pkg::PH_CRC;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            pngcsp_pkg::PH_DATA:
            begin
                dv = (type_reg == pngcsp_pkg::TYPE_IDAT);
                if ((type_reg == pngcsp_pkg::TYPE_IHDR) && (pos_reg < pngcsp_pkg::IHDR_LEN))
                begin
                    if (pos_reg[3:2] == 2'd0)
                    begin
                        width_next = {width_reg[pngcsp_pkg::WORD_W-9:0], stream_byte};
                    end
                    else if (pos_reg[3:2] == 2'd1)
                    begin
                        height_next = {height_reg[pngcsp_pkg::WORD_W-9:0], stream_byte};
                    end
                    else
                    begin
                        case (hdr_idx)
                            3'd0:    hdr_next[0] = stream_byte;
                            3'd1:    hdr_next[1] = stream_byte;
                            3'd2:    hdr_next[2] = stream_byte;
                            3'd3:    hdr_next[3] = stream_byte;
                            3'd4:    hdr_next[4] = stream_byte;
                            default: ;
                        endcase
                    end
                    if (pos_reg == pngcsp_pkg::IHDR_LEN - 32'd1)
                    begin
                        ev = pngcsp_pkg::EV_IHDR;
                    end
                end
                // pos_reg is below len_reg here, so the increment cannot wrap.
                if (pos_inc >= len_reg)
                begin
                    phase_next = pngcsp_pkg::PH_CRC;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            pngcsp_pkg::PH_CRC:
            begin
                if (pos_reg[1:0] == 2'd3)
                begin
                    pos_next = '0;
                    if (last_reg)
                    begin
                        phase_next = pngcsp_pkg::PH_DONE;
                        ev         = pngcsp_pkg::EV_IEND;
                    end
                    else
                    begin
                        phase_next = pngcsp_pkg::PH_LEN;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            pngcsp_pkg::PH_ERR:
            begin
                ev = pngcsp_pkg::EV_SIG_ERR;
            end
            default:
            begin
                ev = pngcsp_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pngcsp_pkg::PH_SIG;
            pos_reg    <= '0;
            len_reg    <= '0;
            type_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            last_reg   <= 1'b0;
            for (int i = 0; i < pngcsp_pkg::HDR_BYTES; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            last_reg   <= last_next;
            hdr_reg    <= hdr_next;
        end
    end

    always_comb
    begin
        res.event_res          = ev;
        res.chunk_length       = len_next;
        res.chunk_type         = type_next;
        res.image_width        = width_next;
        res.image_height       = height_next;
        res.sample_depth       = hdr_next[0];
        res.color_mode         = hdr_next[1];
        res.compression_method = hdr_next[2];
        res.filter_method      = hdr_next[3];
        res.interlace_method   = hdr_next[4];
        res.image_data_valid   = dv;
        res.image_data_byte    = dv ? stream_byte : '0;
    end

endmodule

/* sv/pngcsp_out_reg.sv */
// ----------------------------------------------------------------------------
// PNG chunk parser result register
// Holds one result item for the output stream and frees itself as soon as
// the item is taken, so a new item can be loaded in the same cycle.
// ----------------------------------------------------------------------------
module pngcsp_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  pngcsp_pkg::result_t res_in,
    input  logic                take,
    output logic                busy,
    output logic                valid,
    output pngcsp_pkg::result_t res_out
);

    logic                valid_reg, valid_next;
    pngcsp_pkg::result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    // Busy means the held item is not being taken, so it stays in the register.
    assign busy    = valid_reg && !take;
    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule
